// File: hdl/nebp_pkg.sv
`timescale 1ns / 1ps
// Types, codes and the step table for the Newton-Euler backward pass unit.
// Depends on nothing; the top level and its checker import it.
package nebp_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_DRAIN = 5'b00100,
      S_SAT   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // Command codes on the request channel.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_LINK = 1'b1;

   // Source of the wide multiplier operand.
   typedef enum logic [1:0] {
      A_CHILD_F,
      A_CHILD_M,
      A_FC,
      A_SEL
   } opa_sel_type;

   // Source of the narrow multiplier operand.
   typedef enum logic [2:0] {
      B_ROT0,
      B_ROT1,
      B_ROT2,
      B_OFFSET,
      B_AXIS
   } opb_sel_type;

   // Where a finished dot product or cross term is written.
   typedef enum logic [1:0] {
      K_FC,
      K_RN,
      K_CX,
      K_DOT
   } dest_kind_type;

   // One micro-step of the shared multiply-accumulate unit.
   typedef struct packed {
      opa_sel_type   a_sel;
      logic [1:0]    a_idx;
      opb_sel_type   b_sel;
      logic [1:0]    b_idx;
      logic          sub;
      logic          first;
      logic          last;
      dest_kind_type d_kind;
      logic [1:0]    d_idx;
   } step_type;

   // Step numbers where the sequencer changes phase.
   localparam logic [4:0] STEP_CX_LAST   = 5'd23;
   localparam logic [4:0] STEP_DOT_FIRST = 5'd24;
   localparam logic [4:0] STEP_LAST      = 5'd26;

   function automatic step_type mk_step(input opa_sel_type a_sel, input logic [1:0] a_idx,
                                        input opb_sel_type b_sel, input logic [1:0] b_idx,
                                        input logic sub, input logic first, input logic last,
                                        input dest_kind_type d_kind, input logic [1:0] d_idx);
      step_type s;
      s.a_sel  = a_sel;
      s.a_idx  = a_idx;
      s.b_sel  = b_sel;
      s.b_idx  = b_idx;
      s.sub    = sub;
      s.first  = first;
      s.last   = last;
      s.d_kind = d_kind;
      s.d_idx  = d_idx;
      return s;
   endfunction

   // Program: rotated force and moment rows, the offset cross force, then
   // the axis dot product with the selected joint vector.
   function automatic step_type step_decode(input logic [4:0] step);
      step_type s;
      case (step)
         5'd0:  s = mk_step(A_CHILD_F, 2'd0, B_ROT0, 2'd0, 1'b0, 1'b1, 1'b0, K_FC, 2'd0);
         5'd1:  s = mk_step(A_CHILD_F, 2'd1, B_ROT0, 2'd1, 1'b0, 1'b0, 1'b0, K_FC, 2'd0);
         5'd2:  s = mk_step(A_CHILD_F, 2'd2, B_ROT0, 2'd2, 1'b0, 1'b0, 1'b1, K_FC, 2'd0);
         5'd3:  s = mk_step(A_CHILD_M, 2'd0, B_ROT0, 2'd0, 1'b0, 1'b1, 1'b0, K_RN, 2'd0);
         5'd4:  s = mk_step(A_CHILD_M, 2'd1, B_ROT0, 2'd1, 1'b0, 1'b0, 1'b0, K_RN, 2'd0);
         5'd5:  s = mk_step(A_CHILD_M, 2'd2, B_ROT0, 2'd2, 1'b0, 1'b0, 1'b1, K_RN, 2'd0);
         5'd6:  s = mk_step(A_CHILD_F, 2'd0, B_ROT1, 2'd0, 1'b0, 1'b1, 1'b0, K_FC, 2'd1);
         5'd7:  s = mk_step(A_CHILD_F, 2'd1, B_ROT1, 2'd1, 1'b0, 1'b0, 1'b0, K_FC, 2'd1);
         5'd8:  s = mk_step(A_CHILD_F, 2'd2, B_ROT1, 2'd2, 1'b0, 1'b0, 1'b1, K_FC, 2'd1);
         5'd9:  s = mk_step(A_CHILD_M, 2'd0, B_ROT1, 2'd0, 1'b0, 1'b1, 1'b0, K_RN, 2'd1);
         5'd10: s = mk_step(A_CHILD_M, 2'd1, B_ROT1, 2'd1, 1'b0, 1'b0, 1'b0, K_RN, 2'd1);
         5'd11: s = mk_step(A_CHILD_M, 2'd2, B_ROT1, 2'd2, 1'b0, 1'b0, 1'b1, K_RN, 2'd1);
         5'd12: s = mk_step(A_CHILD_F, 2'd0, B_ROT2, 2'd0, 1'b0, 1'b1, 1'b0, K_FC, 2'd2);
         5'd13: s = mk_step(A_CHILD_F, 2'd1, B_ROT2, 2'd1, 1'b0, 1'b0, 1'b0, K_FC, 2'd2);
         5'd14: s = mk_step(A_CHILD_F, 2'd2, B_ROT2, 2'd2, 1'b0, 1'b0, 1'b1, K_FC, 2'd2);
         5'd15: s = mk_step(A_CHILD_M, 2'd0, B_ROT2, 2'd0, 1'b0, 1'b1, 1'b0, K_RN, 2'd2);
         5'd16: s = mk_step(A_CHILD_M, 2'd1, B_ROT2, 2'd1, 1'b0, 1'b0, 1'b0, K_RN, 2'd2);
         5'd17: s = mk_step(A_CHILD_M, 2'd2, B_ROT2, 2'd2, 1'b0, 1'b0, 1'b1, K_RN, 2'd2);
         // cx = offset x fc, each component a difference of two products.
         5'd18: s = mk_step(A_FC, 2'd2, B_OFFSET, 2'd1, 1'b0, 1'b1, 1'b0, K_CX, 2'd0);
         5'd19: s = mk_step(A_FC, 2'd1, B_OFFSET, 2'd2, 1'b1, 1'b0, 1'b1, K_CX, 2'd0);
         5'd20: s = mk_step(A_FC, 2'd0, B_OFFSET, 2'd2, 1'b0, 1'b1, 1'b0, K_CX, 2'd1);
         5'd21: s = mk_step(A_FC, 2'd2, B_OFFSET, 2'd0, 1'b1, 1'b0, 1'b1, K_CX, 2'd1);
         5'd22: s = mk_step(A_FC, 2'd1, B_OFFSET, 2'd0, 1'b0, 1'b1, 1'b0, K_CX, 2'd2);
         5'd23: s = mk_step(A_FC, 2'd0, B_OFFSET, 2'd1, 1'b1, 1'b0, 1'b1, K_CX, 2'd2);
         // Axis dot the saturated force or moment.
         5'd24: s = mk_step(A_SEL, 2'd0, B_AXIS, 2'd0, 1'b0, 1'b1, 1'b0, K_DOT, 2'd0);
         5'd25: s = mk_step(A_SEL, 2'd1, B_AXIS, 2'd1, 1'b0, 1'b0, 1'b0, K_DOT, 2'd0);
         5'd26: s = mk_step(A_SEL, 2'd2, B_AXIS, 2'd2, 1'b0, 1'b0, 1'b1, K_DOT, 2'd0);
         default: s = mk_step(A_SEL, 2'd0, B_AXIS, 2'd0, 1'b0, 1'b1, 1'b0, K_DOT, 2'd0);
      endcase
      return s;
   endfunction

endpackage

// File: hdl/newton_euler_backward_pass_unit.sv
`timescale 1ns / 1ps
// Recursive Newton-Euler backward pass (tip to base), one link per transaction.
// Depends on nebp_pkg for the sequencer states and the multiply-accumulate step table.
//
// Usage:
//   Request channel (req_*): a transaction with req_cmd low loads the tip force and
//   moment as the running child wrench and gives no response. A transaction with
//   req_cmd high processes one link, fed from tip toward base, and gives exactly one
//   response transaction (rsp_*) with the joint force, moment, torque and a flag
//   that is high if any of the seven result components was clipped.
//   Timing: after a load transaction the block is ready again in the next cycle.
//   A link transaction runs 27 products through one shared multiplier and
//   accumulator under a step sequencer, one product per cycle in each multiply
//   phase; the response is presented and req_ready returns in the same cycle, so
//   links are handled one at a time and the next link can be accepted in that
//   cycle at the earliest. The two multiply phases each end in a drain state, a
//   saturation state lies between them, and a done state waits for the output.
//   The response sits in an output register; a stalled receiver holds it there,
//   and a following link is worked on meanwhile up to the point where its own
//   response is ready to load.
//   Reset (synchronous, active high) clears the child wrench to zero, empties the
//   output register and returns the sequencer to idle.
module newton_euler_backward_pass_unit
   import nebp_pkg::*;
#(
   parameter int COMPONENT_BITS = 20,
   parameter int FRACTION_BITS  = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [3*COMPONENT_BITS-1:0]     req_inertial_force,
   input  logic [3*COMPONENT_BITS-1:0]     req_inertial_moment,
   input  logic [3*COMPONENT_BITS-1:0]     req_rot_row0,
   input  logic [3*COMPONENT_BITS-1:0]     req_rot_row1,
   input  logic [3*COMPONENT_BITS-1:0]     req_rot_row2,
   input  logic [3*COMPONENT_BITS-1:0]     req_offset_vec,
   input  logic [3*COMPONENT_BITS-1:0]     req_axis_vec,
   input  logic                            req_is_prismatic,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3*COMPONENT_BITS-1:0]     rsp_joint_force,
   output logic [3*COMPONENT_BITS-1:0]     rsp_joint_moment,
   output logic signed [COMPONENT_BITS-1:0] rsp_joint_torque,
   output logic                            rsp_saturated
);

   localparam int CB     = COMPONENT_BITS;
   localparam int FB     = FRACTION_BITS;
   localparam int VEC_W  = 3 * CB;
   localparam int RF     = CB - 2;       // fraction bits of a rotation entry
   localparam int OPA_W  = CB + 3;       // rotated child vector components
   localparam int PROD_W = OPA_W + CB;
   localparam int ACC_W  = 2 * CB + 4;
   localparam int SUM_W  = ACC_W + 2;

   localparam logic signed [ACC_W-1:0] HALF_ROT  = ACC_W'(64'sd1 <<< (RF - 1));
   localparam logic signed [ACC_W-1:0] HALF_FRAC = ACC_W'(64'sd1 <<< (FB - 1));
   localparam logic signed [SUM_W-1:0] SAT_MAX   = SUM_W'((64'sd1 <<< (CB - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SAT_MIN   = SUM_W'(-(64'sd1 <<< (CB - 1)));

   // Signed component idx of a packed vector.
   function automatic logic signed [CB-1:0] comp(input logic [VEC_W-1:0] v,
                                                 input logic [1:0] idx);
      logic signed [CB-1:0] c;
      case (idx)
         2'd0:    c = v[CB-1:0];
         2'd1:    c = v[2*CB-1:CB];
         default: c = v[3*CB-1:2*CB];
      endcase
      return c;
   endfunction

   function automatic logic signed [CB-1:0] sat_val(input logic signed [SUM_W-1:0] v);
      logic signed [CB-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[CB-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[CB-1:0];
      end else begin
         r = v[CB-1:0];
      end
      return r;
   endfunction

   function automatic logic sat_hit(input logic signed [SUM_W-1:0] v);
      return (v > SAT_MAX) || (v < SAT_MIN);
   endfunction

   // Sequencer and item registers.
   state_type              state_ff, state_in;
   logic [4:0]             step_ff, step_in;
   logic [VEC_W-1:0]       cf_ff, cf_in;
   logic [VEC_W-1:0]       cm_ff, cm_in;
   logic [VEC_W-1:0]       fin_ff, nin_ff, rot0_ff, rot1_ff, rot2_ff, off_ff, axis_ff;
   logic                   prism_ff;
   logic                   flag_ff, flag_in;

   // Multiply-accumulate pipeline.
   step_type               dec;
   step_type               meta_ff;
   logic                   pv_ff, pv_in;
   logic signed [OPA_W-1:0]  opa;
   logic signed [CB-1:0]     opb;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  prod_ext, acc_base, acc_sum, rounded;
   logic signed [OPA_W-1:0]  fc_ff [3];
   logic signed [OPA_W-1:0]  rn_ff [3];
   logic signed [ACC_W-1:0]  cx_ff [3];
   logic signed [ACC_W-1:0]  dot_ff;

   // Saturation stage and output register.
   logic [VEC_W-1:0]       f_pack, n_pack;
   logic                   sat_any;
   logic signed [CB-1:0]   tq_val;
   logic                   tq_hit;
   logic                   out_free, out_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VEC_W-1:0]       rsp_force_ff, rsp_moment_ff;
   logic signed [CB-1:0]   rsp_torque_ff;
   logic                   rsp_sat_ff;

   logic                   req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign dec       = step_decode(step_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (state_ff == S_DONE) && out_free;

   // Step sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_cmd == CMD_LINK)) begin
               state_in = S_MUL;
               step_in  = '0;
            end
         end
         S_MUL: begin
            step_in = step_ff + 5'd1;
            if ((step_ff == STEP_CX_LAST) || (step_ff == STEP_LAST)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = (step_ff == STEP_DOT_FIRST) ? S_SAT : S_DONE;
         end
         S_SAT: begin
            state_in = S_MUL;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (dec.a_sel)
         A_CHILD_F: opa = OPA_W'(comp(cf_ff, dec.a_idx));
         A_CHILD_M: opa = OPA_W'(comp(cm_ff, dec.a_idx));
         A_FC:      opa = fc_ff[dec.a_idx];
         default:   opa = OPA_W'(comp(prism_ff ? cf_ff : cm_ff, dec.a_idx));
      endcase
      case (dec.b_sel)
         B_ROT0:   opb = comp(rot0_ff, dec.b_idx);
         B_ROT1:   opb = comp(rot1_ff, dec.b_idx);
         B_ROT2:   opb = comp(rot2_ff, dec.b_idx);
         B_OFFSET: opb = comp(off_ff, dec.b_idx);
         default:  opb = comp(axis_ff, dec.b_idx);
      endcase
   end

   assign prod_in = opa * opb;
   assign pv_in   = (state_ff == S_MUL);

   // Accumulate, then round the finished sum to nearest, ties upward.
   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      acc_base = meta_ff.first ? '0 : acc_ff;
      acc_sum  = meta_ff.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
      if ((meta_ff.d_kind == K_FC) || (meta_ff.d_kind == K_RN)) begin
         rounded = (acc_sum + HALF_ROT) >>> RF;
      end else begin
         rounded = (acc_sum + HALF_FRAC) >>> FB;
      end
   end

   // Joint force and moment with clipping, one adder set per component.
   always_comb begin
      logic signed [SUM_W-1:0] fs;
      logic signed [SUM_W-1:0] ns;
      sat_any = 1'b0;
      f_pack  = '0;
      n_pack  = '0;
      for (int k = 0; k < 3; k++) begin
         fs = SUM_W'(comp(fin_ff, 2'(k))) + SUM_W'(fc_ff[k]);
         ns = SUM_W'(comp(nin_ff, 2'(k))) + SUM_W'(rn_ff[k]) + SUM_W'(cx_ff[k]);
         f_pack[k*CB +: CB] = sat_val(fs);
         n_pack[k*CB +: CB] = sat_val(ns);
         sat_any = sat_any | sat_hit(fs) | sat_hit(ns);
      end
   end

   assign tq_val = sat_val(SUM_W'(dot_ff));
   assign tq_hit = sat_hit(SUM_W'(dot_ff));

   // Child wrench and clip flag.
   always_comb begin
      cf_in   = cf_ff;
      cm_in   = cm_ff;
      flag_in = flag_ff;
      if (req_fire && (req_cmd == CMD_LOAD)) begin
         cf_in = req_inertial_force;
         cm_in = req_inertial_moment;
      end else if (state_ff == S_SAT) begin
         cf_in   = f_pack;
         cm_in   = n_pack;
         flag_in = sat_any;
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         pv_ff        <= 1'b0;
         cf_ff        <= '0;
         cm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pv_ff        <= pv_in;
         cf_ff        <= cf_in;
         cm_ff        <= cm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured request fields, taken on every accepted transaction, and the clip flag.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         fin_ff   <= req_inertial_force;
         nin_ff   <= req_inertial_moment;
         rot0_ff  <= req_rot_row0;
         rot1_ff  <= req_rot_row1;
         rot2_ff  <= req_rot_row2;
         off_ff   <= req_offset_vec;
         axis_ff  <= req_axis_vec;
         prism_ff <= req_is_prismatic;
      end
      flag_ff <= flag_in;
   end

   // Multiplier output register and accumulator write-back.
   always_ff @(posedge clock) begin
      if (pv_in) begin
         prod_ff <= prod_in;
         meta_ff <= dec;
      end
      if (pv_ff) begin
         if (meta_ff.last) begin
            case (meta_ff.d_kind)
               K_FC:    fc_ff[meta_ff.d_idx] <= rounded[OPA_W-1:0];
               K_RN:    rn_ff[meta_ff.d_idx] <= rounded[OPA_W-1:0];
               K_CX:    cx_ff[meta_ff.d_idx] <= rounded;
               default: dot_ff <= rounded;
            endcase
         end else begin
            acc_ff <= acc_sum;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_force_ff  <= cf_ff;
         rsp_moment_ff <= cm_ff;
         rsp_torque_ff <= tq_val;
         rsp_sat_ff    <= flag_ff | tq_hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_joint_force  = rsp_force_ff;
   assign rsp_joint_moment = rsp_moment_ff;
   assign rsp_joint_torque = rsp_torque_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

// File: hdl/nebp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Newton-Euler backward pass unit, with its bind.
// Depends on nebp_pkg for the command codes.
module nebp_checker
   import nebp_pkg::*;
#(
   parameter int COMPONENT_BITS = 20,
   parameter int FRACTION_BITS  = 10
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_cmd,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [3*COMPONENT_BITS-1:0]     rsp_joint_force,
   input logic [3*COMPONENT_BITS-1:0]     rsp_joint_moment,
   input logic signed [COMPONENT_BITS-1:0] rsp_joint_torque,
   input logic                            rsp_saturated
);

   localparam int FRAC_CHECK = FRACTION_BITS;

   // The output register is empty after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A link transaction keeps the block busy in the next cycle.
   a_link_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == CMD_LINK)) |=> !req_ready)
      else $error("request ready right after a link transaction, frac %0d", FRAC_CHECK);

   // A load transaction accepted while no response is pending does not make the response valid.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == CMD_LOAD) && !rsp_valid) |=> !rsp_valid)
      else $error("response after a load transaction");

   // A new response only appears while the sequencer is busy.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while idle");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_joint_force) && $stable(rsp_joint_moment)
         && $stable(rsp_joint_torque) && $stable(rsp_saturated)))
      else $error("response payload changed while stalled");

endmodule

bind newton_euler_backward_pass_unit nebp_checker #(
   .COMPONENT_BITS(COMPONENT_BITS),
   .FRACTION_BITS (FRACTION_BITS)
) u_nebp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_cmd         (req_cmd),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_joint_force (rsp_joint_force),
   .rsp_joint_moment(rsp_joint_moment),
   .rsp_joint_torque(rsp_joint_torque),
   .rsp_saturated   (rsp_saturated)
);
